[sv/tcma_pkg.sv]
// Shared widths, channel codes and controller/datapath interface types.
package tcma_pkg;

   localparam int HUM_W  = 10;
   localparam int TEMP_W = 12;
   localparam int STR_W  = 9;
   localparam int USED_W = 4;

   // Quotient width of the divider: wide enough for any channel's mean magnitude.
   localparam int MAG_W  = 12;
   localparam int STEP_W = $clog2(MAG_W);

   typedef enum logic [1:0] {
      CH_HUMIDITY    = 2'd0,
      CH_TEMPERATURE = 2'd1,
      CH_STRENGTH    = 2'd2
   } chan_type;

   typedef struct packed {
      logic [HUM_W-1:0]         hum;
      logic signed [TEMP_W-1:0] temp;
      logic signed [STR_W-1:0]  str;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic     accept;
      logic     update;
      logic     div_load;
      logic     div_step;
      logic     div_store;
      chan_type chan;
      logic     publish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

[sv/tcma_req_if.sv]
// Sample channel: valid/ready handshake carrying one sample triple.
interface tcma_req_if;
   logic                                valid;
   logic                                ready;
   logic [tcma_pkg::HUM_W-1:0]          humidity_sample;
   logic signed [tcma_pkg::TEMP_W-1:0]  temperature_sample;
   logic signed [tcma_pkg::STR_W-1:0]   signal_strength_sample;

   modport source (output valid, output humidity_sample, output temperature_sample,
                   output signal_strength_sample, input ready);
   modport sink   (input valid, input humidity_sample, input temperature_sample,
                   input signal_strength_sample, output ready);
endinterface

[sv/tcma_rsp_if.sv]
// Average channel: valid/ready handshake carrying three means and the fill count.
interface tcma_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tcma_pkg::HUM_W-1:0]          humidity_average;
   logic signed [tcma_pkg::TEMP_W-1:0]  temperature_average;
   logic signed [tcma_pkg::STR_W-1:0]   signal_strength_average;
   logic [tcma_pkg::USED_W-1:0]         samples_used;

   modport source (output valid, output humidity_average, output temperature_average,
                   output signal_strength_average, output samples_used, input ready);
   modport sink   (input valid, input humidity_average, input temperature_average,
                   input signal_strength_average, input samples_used, output ready);
endinterface

[sv/three_channel_moving_average_unit.sv]
// Three-channel moving average over a ring of WINDOW sample triples.
// Each accepted sample word (humidity, temperature, signal strength) is written into a
// WINDOW-entry ring; running sums and a fill count (1 up to WINDOW, then saturated) are
// updated and one average word follows: each sum divided by the count, truncated toward
// zero, plus the count. The ring entry that a sample word replaces is read at its acceptance.
// An update step then updates sums and ring, and each channel passes through the shared
// bit-serial divider (load, 12 quotient bits, store), which the three channels use in
// turn. A publish step then moves the averages into the output register, waiting until
// that register is free. A new sample word is taken in the cycle after that move, even
// while the average waits for the consumer, but not before the last sample word's averages
// have been moved there. No clearing pass is needed after reset.
module three_channel_moving_average_unit #(
   parameter int WINDOW = 10
) (
   input logic        clock,
   input logic        reset,
   tcma_req_if.sink   req_chan,
   tcma_rsp_if.source rsp_chan
);

   tcma_pkg::cmd_type cmd;
   tcma_pkg::sts_type sts;

   tcma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tcma_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .hum_sample   (req_chan.humidity_sample),
      .temp_sample  (req_chan.temperature_sample),
      .str_sample   (req_chan.signal_strength_sample),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .hum_average  (rsp_chan.humidity_average),
      .temp_average (rsp_chan.temperature_average),
      .str_average  (rsp_chan.signal_strength_average),
      .samples_used (rsp_chan.samples_used)
   );

endmodule

[sv/tcma_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tcma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/tcma_ctrl.sv]
// Sequencer: accept, window update, three bit-serial divisions, publish.
module tcma_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output tcma_pkg::cmd_type cmd,
   input  tcma_pkg::sts_type sts
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_UPDATE  = 6'b000010,
      ST_LOAD    = 6'b000100,
      ST_STEP    = 6'b001000,
      ST_STORE   = 6'b010000,
      ST_PUBLISH = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   tcma_pkg::chan_type             chan_ff, chan_in;
   logic [tcma_pkg::STEP_W-1:0]    step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.chan = chan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            chan_in    = tcma_pkg::CH_HUMIDITY;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_STEP;
         end
         ST_STEP: begin
            cmd.div_step = 1'b1;
            if (step_ff == tcma_pkg::STEP_W'(tcma_pkg::MAG_W - 1)) begin
               state_in = ST_STORE;
            end else begin
               step_in = step_ff + tcma_pkg::STEP_W'(1);
            end
         end
         ST_STORE: begin
            cmd.div_store = 1'b1;
            case (chan_ff)
               tcma_pkg::CH_HUMIDITY: begin
                  chan_in  = tcma_pkg::CH_TEMPERATURE;
                  state_in = ST_LOAD;
               end
               tcma_pkg::CH_TEMPERATURE: begin
                  chan_in  = tcma_pkg::CH_STRENGTH;
                  state_in = ST_LOAD;
               end
               default: begin
                  state_in = ST_PUBLISH;
               end
            endcase
         end
         ST_PUBLISH: begin
            // hold the averages until the output register is free
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= tcma_pkg::CH_HUMIDITY;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         step_ff  <= step_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

[sv/tcma_dp.sv]
// Datapath: sample ring, running sums, fill count, shared divider, output register.
module tcma_dp #(
   parameter int WINDOW = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tcma_pkg::cmd_type                   cmd,
   output tcma_pkg::sts_type                   sts,
   input  logic [tcma_pkg::HUM_W-1:0]          hum_sample,
   input  logic signed [tcma_pkg::TEMP_W-1:0]  temp_sample,
   input  logic signed [tcma_pkg::STR_W-1:0]   str_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tcma_pkg::HUM_W-1:0]          hum_average,
   output logic signed [tcma_pkg::TEMP_W-1:0]  temp_average,
   output logic signed [tcma_pkg::STR_W-1:0]   str_average,
   output logic [tcma_pkg::USED_W-1:0]         samples_used
);

   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int HSUM_W = tcma_pkg::HUM_W + CNT_W;
   localparam int TSUM_W = tcma_pkg::TEMP_W + CNT_W;
   localparam int SSUM_W = tcma_pkg::STR_W + CNT_W;
   localparam int DVD_W  = tcma_pkg::MAG_W + CNT_W;
   localparam int HUM_W  = tcma_pkg::HUM_W;
   localparam int TEMP_W = tcma_pkg::TEMP_W;
   localparam int STR_W  = tcma_pkg::STR_W;
   localparam int MAG_W  = tcma_pkg::MAG_W;

   // latched sample
   logic [HUM_W-1:0]          hum_smp_ff;
   logic signed [TEMP_W-1:0]  temp_smp_ff;
   logic signed [STR_W-1:0]   str_smp_ff;

   // window state
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [HSUM_W-1:0]         hum_sum_ff, hum_sum_in;
   logic signed [TSUM_W-1:0]  temp_sum_ff, temp_sum_in;
   logic signed [SSUM_W-1:0]  str_sum_ff, str_sum_in;

   // divider
   logic [CNT_W-1:0]          rem_ff, rem_in;
   logic [MAG_W-1:0]          quo_ff, quo_in;
   logic                      neg_ff, neg_in;

   // staged averages and output register
   logic [HUM_W-1:0]          hum_avg_ff;
   logic signed [TEMP_W-1:0]  temp_avg_ff;
   logic signed [STR_W-1:0]   str_avg_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [HUM_W-1:0]          rsp_hum_ff;
   logic signed [TEMP_W-1:0]  rsp_temp_ff;
   logic signed [STR_W-1:0]   rsp_str_ff;
   logic [tcma_pkg::USED_W-1:0] rsp_used_ff;

   tcma_pkg::entry_type       new_entry;
   tcma_pkg::entry_type       old_entry;
   logic [tcma_pkg::ENTRY_W-1:0] ram_rd_data;
   logic                      full;
   logic [HSUM_W-1:0]         hum_old;
   logic signed [TSUM_W-1:0]  temp_old;
   logic signed [SSUM_W-1:0]  str_old;
   logic signed [DVD_W:0]     sel_sum;
   logic [DVD_W:0]            mag_full;
   logic [DVD_W-1:0]          mag;
   logic [CNT_W:0]            trial;
   logic [CNT_W:0]            diff;
   logic                      fits;
   logic [MAG_W-1:0]          result;

   assign new_entry = '{hum: hum_smp_ff, temp: temp_smp_ff, str: str_smp_ff};

   tcma_ram #(
      .WIDTH (tcma_pkg::ENTRY_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (slot_ff),
      .wr_data (new_entry),
      .rd_en   (cmd.accept),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   assign old_entry = tcma_pkg::entry_type'(ram_rd_data);
   assign full      = (count_ff >= CNT_W'(WINDOW));

   // drop the oldest entry from the sums once the window is full
   always_comb begin
      hum_old  = full ? {{(HSUM_W-HUM_W){1'b0}}, old_entry.hum} : '0;
      temp_old = full ? {{(TSUM_W-TEMP_W){old_entry.temp[TEMP_W-1]}}, old_entry.temp} : '0;
      str_old  = full ? {{(SSUM_W-STR_W){old_entry.str[STR_W-1]}}, old_entry.str} : '0;
      hum_sum_in  = hum_sum_ff;
      temp_sum_in = temp_sum_ff;
      str_sum_in  = str_sum_ff;
      count_in    = count_ff;
      slot_in     = slot_ff;
      if (cmd.update) begin
         hum_sum_in  = hum_sum_ff - hum_old + {{(HSUM_W-HUM_W){1'b0}}, hum_smp_ff};
         temp_sum_in = temp_sum_ff - temp_old
                     + {{(TSUM_W-TEMP_W){temp_smp_ff[TEMP_W-1]}}, temp_smp_ff};
         str_sum_in  = str_sum_ff - str_old
                     + {{(SSUM_W-STR_W){str_smp_ff[STR_W-1]}}, str_smp_ff};
         count_in    = full ? count_ff : count_ff + CNT_W'(1);
         slot_in     = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
      end
   end

   // divider operand: magnitude of the selected sum
   always_comb begin
      case (cmd.chan)
         tcma_pkg::CH_HUMIDITY:    sel_sum = $signed({{(DVD_W+1-HSUM_W){1'b0}}, hum_sum_ff});
         tcma_pkg::CH_TEMPERATURE: sel_sum = {{(DVD_W+1-TSUM_W){temp_sum_ff[TSUM_W-1]}},
                                              temp_sum_ff};
         tcma_pkg::CH_STRENGTH:    sel_sum = {{(DVD_W+1-SSUM_W){str_sum_ff[SSUM_W-1]}},
                                              str_sum_ff};
         default:                  sel_sum = '0;
      endcase
      mag_full = sel_sum[DVD_W] ? -sel_sum : sel_sum;
      mag      = mag_full[DVD_W-1:0];
   end

   // one restoring step: shift in the next dividend bit, subtract count if it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[MAG_W-1]};
      diff   = trial - {1'b0, count_ff};
      fits   = (trial >= {1'b0, count_ff});
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      if (cmd.div_load) begin
         rem_in = mag[DVD_W-1:MAG_W];
         quo_in = mag[MAG_W-1:0];
         neg_in = sel_sum[DVD_W];
      end else if (cmd.div_step) begin
         rem_in = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in = {quo_ff[MAG_W-2:0], fits};
      end
   end

   assign result = neg_ff ? -quo_ff : quo_ff;

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = cmd.publish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         count_ff     <= '0;
         hum_sum_ff   <= '0;
         temp_sum_ff  <= '0;
         str_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         hum_sum_ff   <= hum_sum_in;
         temp_sum_ff  <= temp_sum_in;
         str_sum_ff   <= str_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      if (cmd.accept) begin
         hum_smp_ff  <= hum_sample;
         temp_smp_ff <= temp_sample;
         str_smp_ff  <= str_sample;
      end
      if (cmd.div_store) begin
         case (cmd.chan)
            tcma_pkg::CH_HUMIDITY:    hum_avg_ff  <= result[HUM_W-1:0];
            tcma_pkg::CH_TEMPERATURE: temp_avg_ff <= result[TEMP_W-1:0];
            default:                  str_avg_ff  <= result[STR_W-1:0];
         endcase
      end
      if (cmd.publish) begin
         rsp_hum_ff  <= hum_avg_ff;
         rsp_temp_ff <= temp_avg_ff;
         rsp_str_ff  <= str_avg_ff;
         rsp_used_ff <= tcma_pkg::USED_W'(count_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign hum_average  = rsp_hum_ff;
   assign temp_average = rsp_temp_ff;
   assign str_average  = rsp_str_ff;
   assign samples_used = rsp_used_ff;

endmodule

[sv/tcma_checker.sv]
// Port-level checks on the moving average unit, bound to its top level.
module tcma_checker #(
   parameter int WINDOW = 10
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [tcma_pkg::HUM_W-1:0]          humidity_average,
   input logic signed [tcma_pkg::TEMP_W-1:0]  temperature_average,
   input logic signed [tcma_pkg::STR_W-1:0]   signal_strength_average,
   input logic [tcma_pkg::USED_W-1:0]         samples_used
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("average word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(humidity_average) && $stable(temperature_average)
         && $stable(signal_strength_average) && $stable(samples_used))
      else $error("average word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample accepted on back-to-back cycles");

   a_used_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (WINDOW > 15) || (samples_used != '0))
      else $error("average word reports zero samples used");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("average word valid right after reset");

endmodule

bind three_channel_moving_average_unit tcma_checker #(
   .WINDOW (WINDOW)
) u_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req_chan.valid),
   .req_ready               (req_chan.ready),
   .rsp_valid               (rsp_chan.valid),
   .rsp_ready               (rsp_chan.ready),
   .humidity_average        (rsp_chan.humidity_average),
   .temperature_average     (rsp_chan.temperature_average),
   .signal_strength_average (rsp_chan.signal_strength_average),
   .samples_used            (rsp_chan.samples_used)
);
